// ===== rtl/nscu_pkg.sv =====
package nscu_pkg;

	localparam int IN_IDX_W   = 4;
	localparam int OUT_DIST_W = 16;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_UV  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_U   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_U   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_V   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_V   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_U = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_V = 3'd6;

	localparam logic [OUT_DIST_W-1:0] RST_MIN_UV  = 16'd196;
	localparam logic [OUT_DIST_W-1:0] RST_MIN_U   = 16'd1;
	localparam logic [OUT_DIST_W-1:0] RST_MAX_U   = 16'd9;
	localparam logic [OUT_DIST_W-1:0] RST_MIN_V   = 16'd4;
	localparam logic [OUT_DIST_W-1:0] RST_MAX_V   = 16'd100;
	localparam logic [CNT_W-1:0]      RST_COUNT_U = 4'd5;
	localparam logic [CNT_W-1:0]      RST_COUNT_V = 4'd7;

	typedef struct packed {
		logic [OUT_DIST_W-1:0] min_uv;
		logic [OUT_DIST_W-1:0] min_u;
		logic [OUT_DIST_W-1:0] max_u;
		logic [OUT_DIST_W-1:0] min_v;
		logic [OUT_DIST_W-1:0] max_v;
		logic [CNT_W-1:0]      count_u;
		logic [CNT_W-1:0]      count_v;
	} nscu_cfg_t;

	typedef struct packed {
		logic write;
		logic start;
		logic scan_issue;
		logic caps_issue;
		logic load_out;
	} nscu_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic caps_last;
	} nscu_stat_t;

endpackage

// ===== rtl/nscu_pair_store.sv =====
module nscu_pair_store #(
	parameter int NUM_PENTAGONS = 12,
	parameter int DIST_WIDTH    = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [2*$clog2(NUM_PENTAGONS)-1:0]      wr_addr,
	input  logic [DIST_WIDTH-1:0]                   wr_data,
	input  logic                                    clr,
	input  logic [2*$clog2(NUM_PENTAGONS)-1:0]      rd_addr_a,
	input  logic [2*$clog2(NUM_PENTAGONS)-1:0]      rd_addr_b,
	output logic [DIST_WIDTH-1:0]                   rd_data_a,
	output logic [DIST_WIDTH-1:0]                   rd_data_b
);

	localparam int AW    = $clog2(NUM_PENTAGONS);
	localparam int DEPTH = NUM_PENTAGONS << AW;

	logic [DIST_WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0]      vld_q;
	logic [DIST_WIDTH-1:0] raw_a_q, raw_b_q;
	logic                  vld_a_q, vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_a_q <= mem[rd_addr_a];
		raw_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			vld_a_q <= vld_q[rd_addr_a];
			vld_b_q <= vld_q[rd_addr_b];
		end
	end

	assign rd_data_a = vld_a_q ? raw_a_q : '0;
	assign rd_data_b = vld_b_q ? raw_b_q : '0;

endmodule

// ===== rtl/nscu_ctrl.sv =====
module nscu_ctrl import nscu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       last,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  nscu_stat_t stat,
	output nscu_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_SCAN_END = 6'b000100,
		ST_CAPS     = 6'b001000,
		ST_CAPS_END = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.write      = in_accept;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && last) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_CAPS;
			end
			ST_CAPS: begin
				cmd.caps_issue = 1'b1;
				if (stat.caps_last) begin
					state_d = ST_CAPS_END;
				end
			end
			ST_CAPS_END: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/nscu_dpath.sv =====
module nscu_dpath import nscu_pkg::*; #(
	parameter int NUM_PENTAGONS = 12,
	parameter int DIST_WIDTH    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nscu_cmd_t             cmd,
	output nscu_stat_t            stat,
	input  nscu_cfg_t             cfg,
	input  logic [IN_IDX_W-1:0]   row,
	input  logic [IN_IDX_W-1:0]   col,
	input  logic [OUT_DIST_W-1:0] distance,
	output logic                  accepted,
	output logic                  too_compact,
	output logic [OUT_DIST_W-1:0] end_distance,
	output logic [IN_IDX_W-1:0]   end_u,
	output logic [IN_IDX_W-1:0]   end_v,
	output logic [CNT_W-1:0]      cap_u_count,
	output logic [CNT_W-1:0]      cap_v_count,
	output logic [OUT_DIST_W-1:0] cap_u_min,
	output logic [OUT_DIST_W-1:0] cap_u_max,
	output logic [OUT_DIST_W-1:0] cap_v_min,
	output logic [OUT_DIST_W-1:0] cap_v_max
);

	localparam int AW   = $clog2(NUM_PENTAGONS);
	localparam int CNTW = $clog2(NUM_PENTAGONS);
	localparam int DW   = DIST_WIDTH;
	localparam int CMPW = (DIST_WIDTH > OUT_DIST_W) ? DIST_WIDTH : OUT_DIST_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PENTAGONS - 1);
	localparam logic [AW-1:0] NEXT_LAST_IDX = AW'(NUM_PENTAGONS - 2);

	logic [AW-1:0]   pi_q, pj_q, k_q;
	logic [AW-1:0]   pi_s1, pj_s1, k_s1;
	logic            scan_s1, caps_s1;
	logic [AW-1:0]   u_q, v_q;
	logic [DW-1:0]   duv_q;
	logic [CNTW-1:0] nu_q, nv_q;
	logic [DW-1:0]   mnu_q, mxu_q, mnv_q, mxv_q;

	logic            pair_ok;
	logic [2*AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [DW-1:0]   rd_a, rd_b, half;
	logic            hit_u, hit_v;

	logic            compact, swap, ok;
	logic [AW-1:0]   su, sv;
	logic [CNTW-1:0] snu, snv;
	logic [DW-1:0]   smnu, smxu, smnv, smxv;

	assign pair_ok = (row < col) &&
		((IN_IDX_W+1)'(col) < (IN_IDX_W+1)'(NUM_PENTAGONS));
	assign wr_addr = {row[AW-1:0], col[AW-1:0]};

	always_comb begin
		if (cmd.caps_issue) begin
			rd_addr_a = (u_q < k_q) ? {u_q, k_q} : {k_q, u_q};
			rd_addr_b = (v_q < k_q) ? {v_q, k_q} : {k_q, v_q};
		end else begin
			rd_addr_a = {pi_q, pj_q};
			rd_addr_b = {pi_q, pj_q};
		end
	end

	nscu_pair_store #(
		.NUM_PENTAGONS(NUM_PENTAGONS),
		.DIST_WIDTH   (DIST_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd.write && pair_ok),
		.wr_addr  (wr_addr),
		.wr_data  (DW'(distance)),
		.clr      (cmd.load_out),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	assign stat.scan_last = (pi_q == NEXT_LAST_IDX) && (pj_q == LAST_IDX);
	assign stat.caps_last = (k_q == LAST_IDX);

	assign half  = duv_q >> 1;
	assign hit_u = caps_s1 && (k_s1 != u_q) && (rd_a <= half);
	assign hit_v = caps_s1 && (k_s1 != v_q) && (rd_b <= half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			caps_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_issue;
			caps_s1 <= cmd.caps_issue;
		end
	end

	always_ff @(posedge clk) begin
		pi_s1 <= pi_q;
		pj_s1 <= pj_q;
		k_s1  <= k_q;
		if (cmd.start) begin
			pi_q  <= '0;
			pj_q  <= AW'(1);
			k_q   <= '0;
			u_q   <= '0;
			v_q   <= AW'(1);
			duv_q <= '0;
			nu_q  <= '0;
			nv_q  <= '0;
			mnu_q <= '1;
			mxu_q <= '0;
			mnv_q <= '1;
			mxv_q <= '0;
		end else begin
			if (cmd.scan_issue) begin
				if (pj_q == LAST_IDX) begin
					pi_q <= pi_q + AW'(1);
					pj_q <= pi_q + AW'(2);
				end else begin
					pj_q <= pj_q + AW'(1);
				end
			end
			if (cmd.caps_issue) begin
				k_q <= k_q + AW'(1);
			end
			if (scan_s1 && (rd_a > duv_q)) begin
				duv_q <= rd_a;
				u_q   <= pi_s1;
				v_q   <= pj_s1;
			end
			if (hit_u) begin
				nu_q <= nu_q + CNTW'(1);
				if (rd_a < mnu_q) begin
					mnu_q <= rd_a;
				end
				if (rd_a > mxu_q) begin
					mxu_q <= rd_a;
				end
			end
			if (hit_v) begin
				nv_q <= nv_q + CNTW'(1);
				if (rd_b < mnv_q) begin
					mnv_q <= rd_b;
				end
				if (rd_b > mxv_q) begin
					mxv_q <= rd_b;
				end
			end
		end
	end

	always_comb begin
		compact = CMPW'(duv_q) < CMPW'(cfg.min_uv);
		swap    = !compact && (nu_q > nv_q);
		su      = swap ? v_q : u_q;
		sv      = swap ? u_q : v_q;
		if (compact) begin
			snu  = '0;
			snv  = '0;
			smnu = '1;
			smxu = '0;
			smnv = '1;
			smxv = '0;
		end else begin
			snu  = swap ? nv_q : nu_q;
			snv  = swap ? nu_q : nv_q;
			smnu = swap ? mnv_q : mnu_q;
			smxu = swap ? mxv_q : mxu_q;
			smnv = swap ? mnu_q : mnv_q;
			smxv = swap ? mxu_q : mxv_q;
		end
		ok = !compact &&
			(CMPW'(smnu) >= CMPW'(cfg.min_u)) && (CMPW'(smxu) <= CMPW'(cfg.max_u)) &&
			(CMPW'(smnv) >= CMPW'(cfg.min_v)) && (CMPW'(smxv) <= CMPW'(cfg.max_v)) &&
			((cfg.count_u == '0) || (CNT_W'(snu) == cfg.count_u)) &&
			((cfg.count_v == '0) || (CNT_W'(snv) == cfg.count_v));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			accepted     <= ok;
			too_compact  <= compact;
			end_distance <= OUT_DIST_W'(duv_q);
			end_u        <= IN_IDX_W'(su);
			end_v        <= IN_IDX_W'(sv);
			cap_u_count  <= CNT_W'(snu);
			cap_v_count  <= CNT_W'(snv);
			cap_u_min    <= OUT_DIST_W'(smnu);
			cap_u_max    <= OUT_DIST_W'(smxu);
			cap_v_min    <= OUT_DIST_W'(smnv);
			cap_v_max    <= OUT_DIST_W'(smxv);
		end
	end

endmodule

// ===== rtl/nanocone_shape_classifier_unit.sv =====
// Non-final pair requests are taken one per cycle and stored in a pair memory.
// A final request starts a scan of all P = N*(N-1)/2 pairs over one read port, then
// a cap pass over all N pentagons over two read ports; no request is taken from the
// final request until the result is loaded into the output registers.
// Reset clears the per-entry valid bits (store reads as zero) and loads register
// defaults; the store is cleared again in the cycle a result is loaded.
module nanocone_shape_classifier_unit import nscu_pkg::*; #(
	parameter int NUM_PENTAGONS = 12,
	parameter int DIST_WIDTH    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [IN_IDX_W-1:0]   row,
	input  logic [IN_IDX_W-1:0]   col,
	input  logic [OUT_DIST_W-1:0] distance,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic                  too_compact,
	output logic [OUT_DIST_W-1:0] end_distance,
	output logic [IN_IDX_W-1:0]   end_u,
	output logic [IN_IDX_W-1:0]   end_v,
	output logic [CNT_W-1:0]      cap_u_count,
	output logic [CNT_W-1:0]      cap_v_count,
	output logic [OUT_DIST_W-1:0] cap_u_min,
	output logic [OUT_DIST_W-1:0] cap_u_max,
	output logic [OUT_DIST_W-1:0] cap_v_min,
	output logic [OUT_DIST_W-1:0] cap_v_max,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	nscu_cfg_t  cfg_q;
	nscu_cmd_t  cmd;
	nscu_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_uv  <= RST_MIN_UV;
			cfg_q.min_u   <= RST_MIN_U;
			cfg_q.max_u   <= RST_MAX_U;
			cfg_q.min_v   <= RST_MIN_V;
			cfg_q.max_v   <= RST_MAX_V;
			cfg_q.count_u <= RST_COUNT_U;
			cfg_q.count_v <= RST_COUNT_V;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_UV:  cfg_q.min_uv  <= cfg_data;
				REG_MIN_U:   cfg_q.min_u   <= cfg_data;
				REG_MAX_U:   cfg_q.max_u   <= cfg_data;
				REG_MIN_V:   cfg_q.min_v   <= cfg_data;
				REG_MAX_V:   cfg_q.max_v   <= cfg_data;
				REG_COUNT_U: cfg_q.count_u <= cfg_data[CNT_W-1:0];
				REG_COUNT_V: cfg_q.count_v <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nscu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	nscu_dpath #(
		.NUM_PENTAGONS(NUM_PENTAGONS),
		.DIST_WIDTH   (DIST_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg_q),
		.row         (row),
		.col         (col),
		.distance    (distance),
		.accepted    (accepted),
		.too_compact (too_compact),
		.end_distance(end_distance),
		.end_u       (end_u),
		.end_v       (end_v),
		.cap_u_count (cap_u_count),
		.cap_v_count (cap_v_count),
		.cap_u_min   (cap_u_min),
		.cap_u_max   (cap_u_max),
		.cap_v_min   (cap_v_min),
		.cap_v_max   (cap_v_max)
	);

endmodule
